// File: design/pvd_pkg.sv
// ----------------------------------------------------------------------------
// Peak/valley detector package
// Shared widths, trend codes and the lane status word.
// ----------------------------------------------------------------------------
package pvd_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int INDEX_BITS  = 32;

    // s_tdata: high_sample, low_sample, padded to whole bytes
    localparam int IN_DATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    // m_tdata: position, peak_value, valley_value, padded to whole bytes
    localparam int OUT_DATA_BITS = ((INDEX_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8;

    localparam logic [1:0] TREND_NONE = 2'd0;
    localparam logic [1:0] TREND_RISE = 2'd1;
    localparam logic [1:0] TREND_FALL = 2'd2;

    localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

    typedef struct packed {
        logic                   found;
        logic [SAMPLE_BITS-1:0] value;
    } lane_status_t;

endpackage

// File: design/pvd_lane.sv
// ----------------------------------------------------------------------------
// Peak/valley detector lane
// Tracks one channel: previous sample, last nonzero trend, and flags a turn
// at the previous sample (rise then fall, or fall then rise in valley mode).
// ----------------------------------------------------------------------------
module pvd_lane
    import pvd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valley_mode,
    input  logic                   advance,
    input  logic                   restart,
    input  logic [SAMPLE_BITS-1:0] sample,
    output lane_status_t           status
);

    logic [SAMPLE_BITS-1:0] prev_reg;
    logic [1:0]             trend_reg;
    logic [1:0]             step;
    logic [1:0]             turn_from;
    logic [1:0]             turn_to;

    always_comb
    begin
        if ($signed(sample) > $signed(prev_reg))
        begin
            step = TREND_RISE;
        end
        else if ($signed(sample) < $signed(prev_reg))
        begin
            step = TREND_FALL;
        end
        else
        begin
            step = TREND_NONE;
        end
    end

    assign turn_from = valley_mode ? TREND_FALL : TREND_RISE;
    assign turn_to   = valley_mode ? TREND_RISE : TREND_FALL;

    assign status.found = !restart && (step == turn_to) && (trend_reg == turn_from);
    assign status.value = prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            trend_reg <= TREND_NONE;
        end
        else if (advance)
        begin
            prev_reg <= sample;
            if (restart)
            begin
                trend_reg <= TREND_NONE;
            end
            else if (step != TREND_NONE)
            begin
                // plateaus carry the earlier trend
                trend_reg <= step;
            end
        end
    end

endmodule

// File: design/pvd_merge.sv
// ----------------------------------------------------------------------------
// Peak/valley detector merge stage
// Keeps the series position, combines both lane flags into one result word
// and holds it in an output register with a skid stage.
// ----------------------------------------------------------------------------
module pvd_merge
    import pvd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   series_start,
    input  lane_status_t           high_lane,
    input  lane_status_t           low_lane,
    output logic                   restart,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   peak_found,
    output logic                   valley_found,
    output logic [INDEX_BITS-1:0]  position,
    output logic [SAMPLE_BITS-1:0] peak_value,
    output logic [SAMPLE_BITS-1:0] valley_value
);

    typedef struct packed {
        logic                   peak;
        logic                   valley;
        logic [INDEX_BITS-1:0]  pos;
        logic [SAMPLE_BITS-1:0] peak_val;
        logic [SAMPLE_BITS-1:0] valley_val;
    } result_t;

    logic                  history_valid_reg;
    logic [INDEX_BITS-1:0] count_reg;
    logic [INDEX_BITS-1:0] count_next;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    result_t               out_reg;
    result_t               skid_reg;
    result_t               fresh;
    logic                  accept;
    logic                  push;
    logic                  pop;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign restart  = series_start || !history_valid_reg;
    assign pop      = out_valid_reg && out_ready;
    assign push     = accept && (high_lane.found || low_lane.found);

    assign fresh.peak       = high_lane.found;
    assign fresh.valley     = low_lane.found;
    assign fresh.pos        = count_reg - INDEX_BITS'(1);
    assign fresh.peak_val   = high_lane.found ? high_lane.value : '0;
    assign fresh.valley_val = low_lane.found ? low_lane.value : '0;

    always_comb
    begin
        if (restart)
        begin
            count_next = INDEX_BITS'(1);
        end
        else if (count_reg == INDEX_MAX)
        begin
            count_next = count_reg;
        end
        else
        begin
            count_next = count_reg + INDEX_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_valid_reg <= 1'b0;
            count_reg         <= '0;
        end
        else if (accept)
        begin
            history_valid_reg <= 1'b1;
            count_reg         <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // input is held off; drain the skid word once the output moves
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_reg <= fresh;
            end
            else
            begin
                skid_reg <= fresh;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign peak_found   = out_reg.peak;
    assign valley_found = out_reg.valley;
    assign position     = out_reg.pos;
    assign peak_value   = out_reg.peak_val;
    assign valley_value = out_reg.valley_val;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with an empty output register");

    a_result_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.peak || out_reg.valley))
        else $error("result word carries neither peak nor valley");

    a_history_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> history_valid_reg)
        else $error("history not marked after an accepted word");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        history_valid_reg |-> (count_reg != '0))
        else $error("bar count zero while history is valid");

    a_first_bar_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && restart) |=> !(out_valid_reg && !$past(out_valid_reg)
                                  && !$past(skid_valid_reg)))
        else $error("result raised for the first bar of a series");

endmodule

// File: design/peak_valley_detector.sv
// ----------------------------------------------------------------------------
// Peak/valley detector
// Two lanes watch the high and low samples of each bar; the merge stage
// reports a peak of highs and/or a valley of lows at the previous bar.
//
//   channel   dir  tdata (low bits first)                    tuser
//   s_*       in   high_sample, low_sample                   series_start
//   m_*       out  position, peak_value, valley_value        peak_found, valley_found
//
// One bar per cycle while s_tready is high; a result is registered into the output
// register (or the skid register) as the bar that reveals it is taken. Both lane
// compares and the position update finish in the cycle the bar is taken.
// Reset clears the history, so the first bar after reset starts a series.
// A result word plus one skid word are held while m_tready is low; s_tready
// drops only when both are occupied.
// ----------------------------------------------------------------------------
module peak_valley_detector
    import pvd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // high_sample, low_sample
    input  logic                     s_tuser,   // series_start
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,   // position, peak_value, valley_value
    output logic [1:0]               m_tuser    // peak_found, valley_found
);

    lane_status_t           high_status;
    lane_status_t           low_status;
    logic                   restart;
    logic                   advance;
    logic                   peak_found;
    logic                   valley_found;
    logic [INDEX_BITS-1:0]  position;
    logic [SAMPLE_BITS-1:0] peak_value;
    logic [SAMPLE_BITS-1:0] valley_value;

    assign advance = s_tvalid && s_tready;

    pvd_lane u_high_lane (
        .clk         (clk),
        .rst_n       (rst_n),
        .valley_mode (1'b0),
        .advance     (advance),
        .restart     (restart),
        .sample      (s_tdata[SAMPLE_BITS-1:0]),
        .status      (high_status)
    );

    pvd_lane u_low_lane (
        .clk         (clk),
        .rst_n       (rst_n),
        .valley_mode (1'b1),
        .advance     (advance),
        .restart     (restart),
        .sample      (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .status      (low_status)
    );

    pvd_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .series_start (s_tuser),
        .high_lane    (high_status),
        .low_lane     (low_status),
        .restart      (restart),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .peak_found   (peak_found),
        .valley_found (valley_found),
        .position     (position),
        .peak_value   (peak_value),
        .valley_value (valley_value)
    );

    assign m_tdata = OUT_DATA_BITS'({valley_value, peak_value, position});
    assign m_tuser = {valley_found, peak_found};

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// Peak/valley detector testbench
// Drives bars into the slave stream, predicts the peak and valley words the
// detector should report, and checks each word taken from the master stream
// in order. Runs a directed set of edge cases and then random series, with
// phases of sender idling, receiver stalling and both.
// ----------------------------------------------------------------------------
module tb_top;
    import pvd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        logic                   peak_found;
        logic                   valley_found;
        logic [INDEX_BITS-1:0]  position;
        logic [SAMPLE_BITS-1:0] peak_value;
        logic [SAMPLE_BITS-1:0] valley_value;
    } turn_word_t;

    class turn_scoreboard;
        logic [SAMPLE_BITS-1:0] last_high;
        logic [SAMPLE_BITS-1:0] last_low;
        logic [1:0]             high_dir;
        logic [1:0]             low_dir;
        logic [INDEX_BITS-1:0]  bars_in_series;
        bit                     have_history;
        turn_word_t             due_turns[$];
        int                     errors;

        function new();
            last_high      = '0;
            last_low       = '0;
            high_dir       = TREND_NONE;
            low_dir        = TREND_NONE;
            bars_in_series = '0;
            have_history   = 1'b0;
            errors         = 0;
        endfunction

        function logic [1:0] step_of(logic [SAMPLE_BITS-1:0] prev,
                                     logic [SAMPLE_BITS-1:0] cur);
            if ($signed(cur) > $signed(prev))
                return TREND_RISE;
            if ($signed(cur) < $signed(prev))
                return TREND_FALL;
            return TREND_NONE;
        endfunction

        function int pending();
            return due_turns.size();
        endfunction

        // Advance the prediction by one accepted bar.
        function void take_bar(bit start, logic [SAMPLE_BITS-1:0] hi,
                               logic [SAMPLE_BITS-1:0] lo);
            turn_word_t w;
            logic [1:0] sh;
            logic [1:0] sl;
            if (start || !have_history)
            begin
                high_dir       = TREND_NONE;
                low_dir        = TREND_NONE;
                bars_in_series = '0;
            end
            else
            begin
                sh = step_of(last_high, hi);
                sl = step_of(last_low, lo);
                w.peak_found   = (sh == TREND_FALL) && (high_dir == TREND_RISE);
                w.valley_found = (sl == TREND_RISE) && (low_dir == TREND_FALL);
                // plateaus carry the earlier trend
                if (sh != TREND_NONE)
                    high_dir = sh;
                if (sl != TREND_NONE)
                    low_dir = sl;
                if (w.peak_found || w.valley_found)
                begin
                    w.position     = bars_in_series - 1'b1;
                    w.peak_value   = w.peak_found ? last_high : '0;
                    w.valley_value = w.valley_found ? last_low : '0;
                    due_turns.push_back(w);
                end
            end
            last_high    = hi;
            last_low     = lo;
            have_history = 1'b1;
            if (bars_in_series != INDEX_MAX)
                bars_in_series = bars_in_series + 1'b1;
        endfunction

        function void match_turn(logic [1:0] tuser, logic [OUT_DATA_BITS-1:0] tdata);
            turn_word_t got;
            turn_word_t exp_w;
            got.peak_found   = tuser[0];
            got.valley_found = tuser[1];
            got.position     = tdata[INDEX_BITS-1:0];
            got.peak_value   = tdata[INDEX_BITS +: SAMPLE_BITS];
            got.valley_value = tdata[INDEX_BITS+SAMPLE_BITS +: SAMPLE_BITS];
            if (due_turns.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: peak=%0b valley=%0b pos=%0d pv=%h vv=%h",
                             got.peak_found, got.valley_found, got.position,
                             got.peak_value, got.valley_value);
                return;
            end
            exp_w = due_turns.pop_front();
            if (got.peak_found !== exp_w.peak_found
                || got.valley_found !== exp_w.valley_found
                || got.position !== exp_w.position
                || got.peak_value !== exp_w.peak_value
                || got.valley_value !== exp_w.valley_value)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("wrong word: exp peak=%0b valley=%0b pos=%0d pv=%h vv=%h",
                             exp_w.peak_found, exp_w.valley_found, exp_w.position,
                             exp_w.peak_value, exp_w.valley_value);
                    $display("            got peak=%0b valley=%0b pos=%0d pv=%h vv=%h",
                             got.peak_found, got.valley_found, got.position,
                             got.peak_value, got.valley_value);
                end
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;   // high_sample, low_sample
    logic                     s_tuser;   // series_start
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;   // position, peak_value, valley_value
    logic [1:0]               m_tuser;   // peak_found, valley_found

    turn_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    bit             long_hold_req;
    bit             hold_done;
    bit             receiver_on;
    int             quiet_cycles;

    peak_valley_detector i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one bar, with random idle cycles first, and note it once taken.
    task automatic send_bar(bit start, logic [SAMPLE_BITS-1:0] hi,
                            logic [SAMPLE_BITS-1:0] lo);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {lo, hi};
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_bar(start, hi, lo);
    endtask

    // Hold the sender until every predicted word has arrived.
    task automatic drain_turns();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] next_sample(logic [SAMPLE_BITS-1:0] prev);
        int pick;
        pick = $urandom_range(19);
        if (pick < 5)
            return prev;
        if (pick == 5)
            return $urandom;
        if (pick == 6)
            return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        if ($urandom_range(1))
            return prev + $urandom_range(1000, 1);
        return prev - $urandom_range(1000, 1);
    endfunction

    // Random series: mostly short walks with plateaus, a few long ones,
    // now and then a series that runs on without a start flag.
    task automatic random_bars(int count);
        int                     sent;
        int                     len;
        bit                     start;
        logic [SAMPLE_BITS-1:0] hi;
        logic [SAMPLE_BITS-1:0] lo;
        sent = 0;
        while (sent < count)
        begin
            len   = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
            start = ($urandom_range(9) != 0);
            hi    = $urandom;
            lo    = ($urandom_range(3) == 0) ? $urandom : hi - $urandom_range(1000);
            for (int k = 0; k < len && sent < count; k++)
            begin
                send_bar(k == 0 ? start : ($urandom_range(49) == 0), hi, lo);
                sent++;
                hi = next_sample(hi);
                lo = next_sample(lo);
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        wait (receiver_on);
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.match_turn(m_tuser, m_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("peak_valley_detector: mismatch");
            $finish;
        end
    end

    initial
    begin
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold_req  = 1'b0;
        receiver_on    = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        m_tready <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        receiver_on = 1'b1;

        // first bar after reset without a start flag, then a leading plateau
        send_bar(1'b0, 32'd0, 32'd0);
        send_bar(1'b0, 32'd0, 32'd0);
        send_bar(1'b0, 32'd5, -32'sd5);
        send_bar(1'b0, 32'd5, -32'sd5);
        // peak and valley together, at the end of a plateau
        send_bar(1'b0, 32'd3, -32'sd2);
        send_bar(1'b0, 32'h7fff_ffff, 32'h8000_0000);
        send_bar(1'b0, 32'h8000_0000, 32'h7fff_ffff);
        send_bar(1'b0, 32'h8000_0000, 32'h7fff_ffff);
        send_bar(1'b0, 32'h7fff_ffff, 32'h8000_0000);
        // new series in mid-stream
        send_bar(1'b1, 32'd10, 32'd10);
        send_bar(1'b0, 32'd20, 32'd20);
        send_bar(1'b0, 32'd10, 32'd30);
        send_bar(1'b0, 32'd15, 32'd5);
        send_bar(1'b0, 32'd15, 32'd25);
        send_bar(1'b1, 32'hffff_ffff, 32'hffff_ffff);
        send_bar(1'b0, 32'd0, 32'd0);
        send_bar(1'b0, 32'hffff_ffff, 32'd1);
        send_bar(1'b1, 32'haaaa_aaaa, 32'h5555_5555);
        send_bar(1'b0, 32'h5555_5555, 32'haaaa_aaaa);
        send_bar(1'b0, 32'haaaa_aaaa, 32'h5555_5555);
        send_bar(1'b0, 32'h5555_5555, 32'haaaa_aaaa);
        send_bar(1'b1, 32'h8000_0000, 32'h7fff_ffff);
        send_bar(1'b0, 32'h8000_0001, 32'h7fff_fffe);
        send_bar(1'b0, 32'h8000_0000, 32'h7fff_ffff);
        drain_turns();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            random_bars(60);
            // fill the block against a stopped receiver
            if (phase == 0)
                long_hold_req = 1'b1;
            if (phase == 2)
                drain_turns();
            random_bars(90);
            drain_turns();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("peak_valley_detector: match");
        else
            $display("peak_valley_detector: mismatch");
        $finish;
    end

endmodule

// File: sim.f
design/pvd_pkg.sv
design/pvd_lane.sv
design/pvd_merge.sv
design/peak_valley_detector.sv
test/tb_top.sv
